// ----- rtl/apm_pkg.sv -----
// package: shared constants, register indexes and state type for the axicon phase mask adder
`timescale 1ns / 1ps
package apm_pkg;

  localparam int MAX_DIM_DEF = 4096;
  localparam int PHASE_W     = 16;
  localparam int DIM_W       = 13;
  localparam int INV_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int RAD_SHIFT   = 16;
  localparam int FRAC_LSB    = 17;

  localparam logic [DIM_W-1:0] WIDTH_RST      = DIM_W'(1024);
  localparam logic [DIM_W-1:0] HEIGHT_RST     = DIM_W'(1024);
  localparam logic [INV_W-1:0] INV_RADIUS_RST = INV_W'(32'h0100_0000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH      = 2'd0,
    REG_HEIGHT     = 2'd1,
    REG_INV_RADIUS = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_FINISH,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/apm_if.sv -----
// interfaces: input phase channel and result channel with valid/ready handshake
`timescale 1ns / 1ps
interface apm_in_if;
  logic                         valid;
  logic                         ready;
  logic [apm_pkg::PHASE_W-1:0]  phase_in;

  modport source (output valid, output phase_in, input ready);
  modport sink   (input valid, input phase_in, output ready);
endinterface

interface apm_out_if;
  logic                         valid;
  logic                         ready;
  logic [apm_pkg::PHASE_W-1:0]  phase_out;
  logic                         frame_end;

  modport source (output valid, output phase_out, output frame_end, input ready);
  modport sink   (input valid, input phase_out, input frame_end, output ready);
endinterface

// ----- rtl/axicon_phase_mask_adder.sv -----
// top level: axicon phase mask adder with bit-serial square root and shift-add scaling
//
// in_ch carries one phase word per pixel in raster order; out_ch returns one
// phase word per pixel, with frame_end set on the last pixel of the frame.
// cfg_we/cfg_index/cfg_wdata write frame width, frame height and the
// reciprocal radius; the user must let writes go in only while the block is
// idle; the block itself does not enforce it.
// each accepted word passes through the square, sum, root, finish and done
// states; the next word is accepted only once the result is loaded into the
// output register, so a new word is not taken before the last one is through.
// the restoring square root retires one root bit per cycle, with the radius
// scaling riding one bit behind it.
// the output register holds a finished word while the receiver stalls, and
// a new word is taken and worked on meanwhile; a second finished word waits
// in its last stage until the output register frees up.
// reset clears the row and column counters, the handshake state and the
// configuration registers to 1024 x 1024 and a radius scale of 1.0.
`timescale 1ns / 1ps
module axicon_phase_mask_adder #(
  parameter int MAX_DIM = apm_pkg::MAX_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [apm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [apm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  apm_in_if.sink                           in_ch,
  apm_out_if.source                        out_ch
);
  import apm_pkg::*;

  localparam int CW  = $clog2(MAX_DIM);
  localparam int XW  = CW + 1;
  localparam int SW  = 2 * XW;
  localparam int QW  = (SW + 1 + RAD_SHIFT + 1) / 2;
  localparam int RW  = 2 * QW;
  localparam int RMW = QW + 1;
  localparam int AW  = QW + INV_W;
  localparam int NW  = $clog2(QW);

  function automatic logic [XW-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [XW-1:0] r;
    if (v == '0) begin
      r = XW'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      r = XW'(MAX_DIM);
    end else begin
      r = XW'(v);
    end
    return r;
  endfunction

  logic [DIM_W-1:0] cfg_width_r;
  logic [DIM_W-1:0] cfg_height_r;
  logic [INV_W-1:0] inv_radius_r;

  state_t state_r, state_nxt;

  logic [CW-1:0]      col_r;
  logic [CW-1:0]      row_r;
  logic [XW-1:0]      dx_r;
  logic [XW-1:0]      dy_r;
  logic [PHASE_W-1:0] phase_r;
  logic               end_r;
  logic [SW-1:0]      sqx_r;
  logic [SW-1:0]      sqy_r;
  logic [RW-1:0]      rad_r;
  logic [RMW-1:0]     rem_r;
  logic [QW-1:0]      root_r;
  logic [AW-1:0]      acc_r;
  logic [NW-1:0]      cnt_r;

  logic               out_valid_r;
  logic [PHASE_W-1:0] phase_out_r;
  logic               frame_end_r;

  logic               in_acc;
  logic               load_out;
  logic [XW-1:0]      w_dim;
  logic [XW-1:0]      h_dim;
  logic               last_col;
  logic               last_row;
  logic [XW-1:0]      twice_col;
  logic [XW-1:0]      twice_row;
  logic [XW-1:0]      dx;
  logic [XW-1:0]      dy;
  logic [SW:0]        sq_sum;
  logic [RMW+1:0]     rem_t;
  logic [RMW+1:0]     trial;
  logic               root_bit;
  logic [AW-1:0]      acc_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= WIDTH_RST;
      cfg_height_r <= HEIGHT_RST;
      inv_radius_r <= INV_RADIUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH:      cfg_width_r  <= cfg_wdata[DIM_W-1:0];
        REG_HEIGHT:     cfg_height_r <= cfg_wdata[DIM_W-1:0];
        REG_INV_RADIUS: inv_radius_r <= cfg_wdata[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // pixel position and distance
  always_comb begin
    w_dim     = clamp_dim(cfg_width_r);
    h_dim     = clamp_dim(cfg_height_r);
    last_col  = XW'(col_r) >= (w_dim - XW'(1));
    last_row  = XW'(row_r) >= (h_dim - XW'(1));
    twice_col = {col_r, 1'b0};
    twice_row = {row_r, 1'b0};
    dx        = (twice_col >= w_dim) ? (twice_col - w_dim) : (w_dim - twice_col);
    dy        = (twice_row >= h_dim) ? (twice_row - h_dim) : (h_dim - twice_row);
  end

  // root step and shift-add scaling one bit behind
  always_comb begin
    sq_sum   = (SW + 1)'(sqx_r) + (SW + 1)'(sqy_r);
    rem_t    = {rem_r, rad_r[RW-1 -: 2]};
    trial    = (RMW + 2)'({root_r, 2'b01});
    root_bit = rem_t >= trial;
    acc_nxt  = (acc_r << 1) + (root_r[0] ? AW'(inv_radius_r) : '0);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_ch.valid) state_nxt = ST_SQUARE;
      ST_SQUARE: state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_ROOT;
      ST_ROOT:   if (cnt_r == '0) state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_DONE;
      ST_DONE:   if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    in_acc      = in_ch.valid && in_ch.ready;
    load_out    = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.phase_out = phase_out_r;
  assign out_ch.frame_end = frame_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + CW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dx_r    <= dx;
      dy_r    <= dy;
      phase_r <= in_ch.phase_in;
      end_r   <= last_col && last_row;
    end
    if (load_out) begin
      phase_out_r <= phase_r + acc_r[FRAC_LSB +: PHASE_W];
      frame_end_r <= end_r;
    end
    case (state_r)
      ST_SQUARE: begin
        sqx_r <= SW'(dx_r) * SW'(dx_r);
        sqy_r <= SW'(dy_r) * SW'(dy_r);
      end
      ST_SUM: begin
        rad_r  <= RW'({sq_sum, {RAD_SHIFT{1'b0}}});
        rem_r  <= '0;
        root_r <= '0;
        acc_r  <= '0;
        cnt_r  <= NW'(QW - 1);
      end
      ST_ROOT: begin
        rem_r  <= root_bit ? RMW'(rem_t - trial) : RMW'(rem_t);
        root_r <= {root_r[QW-2:0], root_bit};
        rad_r  <= rad_r << 2;
        acc_r  <= acc_nxt;
        cnt_r  <= cnt_r - NW'(1);
      end
      ST_FINISH: begin
        acc_r <= acc_nxt;
      end
      default: ;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_SQUARE)
    else $error("accepted word did not start the square stage");

  a_root_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROOT && cnt_r == '0) |=> state_r == ST_FINISH)
    else $error("root loop did not end after its last bit");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !out_valid_r) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished word not loaded into empty output register");

  a_col_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && last_col) |=> col_r == '0)
    else $error("column counter did not wrap at row end");

endmodule

// ----- tb/sv/testbench.sv -----
// testbench: axicon phase mask adder checked word by word against a built-in predictor
`timescale 1ns / 1ps
module testbench;
  import apm_pkg::*;

  localparam int unsigned WORD_TARGET = 450;
  localparam int unsigned QUIET_AFTER = 390;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               frame_end;
  } mask_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  apm_in_if  in_ch ();
  apm_out_if out_ch ();

  axicon_phase_mask_adder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [DIM_W-1:0] mask_width  = WIDTH_RST;
  logic [DIM_W-1:0] mask_height = HEIGHT_RST;
  logic [INV_W-1:0] mask_inv    = INV_RADIUS_RST;
  int unsigned      col_pos     = 0;
  int unsigned      row_pos     = 0;

  mask_word_t  mask_words_due[$];
  bit          idle_on = 1'b0;
  logic        last_frame_end;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned frame_ends = 0;
  int unsigned settings = 0;
  int unsigned fail_count = 0;

  function automatic longint unsigned dim_eff(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
    return v;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned root;
    longint unsigned cand;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= n) root = cand;
    end
    return root;
  endfunction

  function automatic mask_word_t masked_phase(input logic [PHASE_W-1:0] ph);
    longint unsigned w, h, dx, dy, q, prod;
    logic [PHASE_W-1:0] frac;
    logic last_col, last_row;
    mask_word_t r;
    w = dim_eff(mask_width);
    h = dim_eff(mask_height);
    dx = (2 * col_pos >= w) ? 2 * col_pos - w : w - 2 * col_pos;
    dy = (2 * row_pos >= h) ? 2 * row_pos - h : h - 2 * row_pos;
    q = root_floor((dx * dx + dy * dy) << RAD_SHIFT);
    prod = q * longint'(mask_inv);
    frac = prod[FRAC_LSB +: PHASE_W];
    last_col = (col_pos >= w - 1);
    last_row = (row_pos >= h - 1);
    r.phase = ph + frac;
    r.frame_end = last_col && last_row;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_WIDTH:      mask_width = data[DIM_W-1:0];
      REG_HEIGHT:     mask_height = data[DIM_W-1:0];
      REG_INV_RADIUS: mask_inv = data[INV_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_phase(input logic [PHASE_W-1:0] ph);
    mask_word_t due;
    int gap;
    if (words_sent >= QUIET_AFTER) idle_on = 1'b0;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.phase_in <= ph;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    due = masked_phase(ph);
    mask_words_due.push_back(due);
    words_sent++;
    last_frame_end = due.frame_end;
  endtask

  // sender holds off until every word has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (mask_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 13) return DIM_W'($urandom_range(1, 8));
    if (sel < 16) return DIM_W'($urandom_range(9, 40));
    if (sel < 18) return DIM_W'($urandom_range(0, 8191));
    if (sel == 18) return '0;
    return DIM_W'($urandom_range(4096, 8191));
  endfunction

  function automatic logic [INV_W-1:0] pick_radius();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: return $urandom();
      4, 5:       return INV_W'($urandom_range(0, 32'h0400_0000));
      6:          return '0;
      7:          return '1;
      8:          return INV_W'($urandom_range(1, 8)) << 24;
      default:    return $urandom() & 32'h00FF_FFFF;
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_phase('0);
    send_phase('1);
    send_phase(PHASE_W'($urandom()));
  endtask

  task automatic test_dimension_limits();
    drain_results();
    write_reg(REG_WIDTH, '0);
    write_reg(REG_HEIGHT, '0);
    settings++;
    send_phase('1);
    send_phase('0);
    drain_results();
    write_reg(REG_WIDTH, 32'd8191);
    write_reg(REG_HEIGHT, 32'd4097);
    write_reg(REG_INV_RADIUS, 32'hFFFF_FFFF);
    settings++;
    send_phase('1);
    send_phase(PHASE_W'($urandom()));
  endtask

  task automatic test_zero_radius();
    drain_results();
    write_reg(REG_WIDTH, 32'd4096);
    write_reg(REG_HEIGHT, 32'd4096);
    write_reg(REG_INV_RADIUS, '0);
    settings++;
    send_phase('1);
    send_phase(PHASE_W'($urandom()));
  endtask

  task automatic test_midframe_resize();
    drain_results();
    write_reg(REG_WIDTH, 32'd6);
    write_reg(REG_HEIGHT, 32'd4);
    write_reg(REG_INV_RADIUS, 32'h0123_4567);
    settings++;
    repeat (9) send_phase(PHASE_W'($urandom()));
    drain_results();
    // column past the new last column ends the row
    write_reg(REG_WIDTH, 32'd2);
    settings++;
    repeat (2) send_phase(PHASE_W'($urandom()));
    drain_results();
    // row past the new last row ends the frame at its row end
    write_reg(REG_HEIGHT, 32'd1);
    settings++;
    repeat (3) send_phase(PHASE_W'($urandom()));
  endtask

  task automatic test_unknown_index();
    drain_results();
    write_reg(REG_NONE, 32'hFFFF_FFFF);
    write_reg(REG_NONE, '0);
    repeat (2) send_phase(PHASE_W'($urandom()));
  endtask

  task automatic test_random_frames();
    int unsigned ends;
    int unsigned target;
    int unsigned pix;
    while (words_sent < WORD_TARGET) begin
      drain_results();
      idle_on = (words_sent < QUIET_AFTER) && ($urandom_range(0, 3) != 0);
      write_reg(REG_WIDTH, 32'(pick_dim()));
      write_reg(REG_HEIGHT, 32'(pick_dim()));
      write_reg(REG_INV_RADIUS, pick_radius());
      if ($urandom_range(0, 9) == 0) write_reg(REG_NONE, $urandom());
      settings++;
      if (dim_eff(mask_width) * dim_eff(mask_height) <= 64) begin
        ends = 0;
        target = $urandom_range(1, 2);
        while (ends < target && words_sent < WORD_TARGET) begin
          send_phase(PHASE_W'($urandom()));
          if (last_frame_end) ends++;
        end
      end else begin
        pix = $urandom_range(1, 24);
        while (pix > 0 && words_sent < WORD_TARGET) begin
          send_phase(PHASE_W'($urandom()));
          pix--;
        end
      end
    end
  endtask

  initial begin : result_ready_driver
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        hold = $urandom_range(0, 4);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : result_check
    mask_word_t due;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (mask_words_due.size() == 0) begin
          $display("%0t unexpected word: expected none, actual phase_out %h frame_end %b",
                   $time, out_ch.phase_out, out_ch.frame_end);
          fail_count++;
        end else begin
          due = mask_words_due.pop_front();
          if (out_ch.phase_out !== due.phase) begin
            $display("%0t phase_out mismatch: expected %h, actual %h",
                     $time, due.phase, out_ch.phase_out);
            fail_count++;
          end
          if (out_ch.frame_end !== due.frame_end) begin
            $display("%0t frame_end mismatch: expected %b, actual %b",
                     $time, due.frame_end, out_ch.frame_end);
            fail_count++;
          end
          if (due.frame_end) frame_ends++;
          words_checked++;
        end
      end
    end
  end

  initial begin : handshake_watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("%0t timeout: no word moved for %0d cycles", $time, quiet);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : run_tests
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_WIDTH;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.phase_in <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_dimension_limits();
    test_zero_radius();
    test_midframe_resize();
    test_unknown_index();
    test_random_frames();
    drain_results();
    if (mask_words_due.size() != 0) begin
      $display("%0t %0d words never arrived", $time, mask_words_due.size());
      fail_count++;
    end
    $display("checked %0d of %0d pixel words over %0d register settings, %0d frame ends",
             words_checked, words_sent, settings, frame_ends);
    $display("included clamped and zero sizes, zero and full radius, mid-frame resize");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- axicon_phase_mask_adder.f -----
rtl/apm_pkg.sv
rtl/apm_if.sv
rtl/axicon_phase_mask_adder.sv
tb/sv/testbench.sv
